### src/itoa_pkg.sv
package itoa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MODE_WIDTH  = 2;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned LEN_WIDTH   = 4;
  localparam int unsigned DIGIT_WIDTH = 4;

  localparam logic [MODE_WIDTH-1:0] MODE_SDEC = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_UDEC = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_HEXL = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_HEXU = 2'd3;

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UP_A  = 8'h41;

  localparam int unsigned DIG_DEPTH = 10;
  localparam int unsigned IDX_WIDTH = $clog2(DIG_DEPTH + 1);

  // Reciprocal of ten: (x * RECIP_TEN) >> RECIP_SHIFT equals x / 10 for every 32-bit x.
  localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned            RECIP_SHIFT = 35;
  localparam int unsigned            QUOT_WIDTH  = 2 * VALUE_WIDTH - RECIP_SHIFT;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [MODE_WIDTH-1:0]  mode_t;
  typedef logic [CHAR_WIDTH-1:0]  char_t;
  typedef logic [LEN_WIDTH-1:0]   len_t;
  typedef logic [DIGIT_WIDTH-1:0] digit_t;
  typedef logic [IDX_WIDTH-1:0]   idx_t;

  function automatic char_t digit_char(input digit_t digit, input logic upper);
    char_t ch;
    if (digit < 4'd10) begin
      ch = CHAR_ZERO + char_t'(digit);
    end else if (upper) begin
      ch = CHAR_UP_A + char_t'(digit - 4'd10);
    end else begin
      ch = CHAR_LOW_A + char_t'(digit - 4'd10);
    end
    return ch;
  endfunction

endpackage

### src/itoa_if.sv
interface itoa_in_if;
  import itoa_pkg::*;

  logic   valid;
  logic   ready;
  logic signed [VALUE_WIDTH-1:0] value;
  mode_t  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink (input valid, input value, input mode, output ready);
endinterface

interface itoa_out_if;
  import itoa_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;
  len_t  total_length;

  modport source (output valid, output char_code, output last, output total_length,
                  input ready);
  modport sink (input valid, input char_code, input last, input total_length,
                output ready);
endinterface

### src/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// The input channel takes one beat per number: a 32-bit signed value and a
// two-bit mode (signed decimal, unsigned decimal, lowercase hex, uppercase hex).
// The output channel returns the text one character per beat, most significant
// digit first, with a leading minus sign for negative values in signed decimal
// mode. Every beat carries the total character count, and the final beat of a
// number has last set.
// Decimal digits are extracted one at a time by a shared reciprocal multiplier,
// hex digits by a shift: each digit passes a multiply state (a multiply by the
// reciprocal of ten) and then a remainder step that stores it. Once all digits
// are stored, one character leaves per cycle while the receiver is ready. A
// result has at most eleven characters. The input is not ready until the last
// character has been handed to the output register. A stalled receiver holds
// the current beat and pauses emission. Reset drops any number in flight and
// empties the output register.
module integer_to_ascii_formatter (
  input  logic clk,
  input  logic rst_n,
  itoa_in_if.sink    in_bus,
  itoa_out_if.source out_bus
);
  import itoa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIG  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  value_t     mag_r, mag_nxt;
  logic [QUOT_WIDTH-1:0] quot_r, quot_nxt;
  mode_t      mode_r, mode_nxt;
  logic       neg_r, neg_nxt;
  logic       sign_pend_r, sign_pend_nxt;
  idx_t       nd_r, nd_nxt;
  idx_t       idx_r, idx_nxt;
  len_t       total_r, total_nxt;
  digit_t     dig_r [DIG_DEPTH];

  logic       out_valid_r, out_valid_nxt;
  char_t      out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  len_t       out_len_r, out_len_nxt;

  logic [2*VALUE_WIDTH-1:0] prod;
  logic       hex_mode;
  value_t     quot_step;
  value_t     rem_full;
  digit_t     digit;
  logic       dig_we;
  logic       out_free;
  logic       in_fire;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign hex_mode     = (mode_r == MODE_HEXL) || (mode_r == MODE_HEXU);

  assign prod      = mag_r * RECIP_TEN;
  assign quot_step = hex_mode ? (mag_r >> 4) : value_t'(quot_r);
  assign rem_full  = mag_r - value_t'(quot_step * value_t'(10));
  assign digit     = hex_mode ? mag_r[DIGIT_WIDTH-1:0] : rem_full[DIGIT_WIDTH-1:0];
  assign dig_we    = (state_r == ST_DIG);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    quot_nxt      = quot_r;
    mode_nxt      = mode_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    nd_nxt        = nd_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt = in_bus.mode;
          nd_nxt   = '0;
          if ((in_bus.mode == MODE_SDEC) && in_bus.value[VALUE_WIDTH-1]) begin
            neg_nxt = 1'b1;
            mag_nxt = value_t'(-in_bus.value);
          end else begin
            neg_nxt = 1'b0;
            mag_nxt = value_t'(in_bus.value);
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        quot_nxt  = prod[2*VALUE_WIDTH-1:RECIP_SHIFT];
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        mag_nxt = quot_step;
        nd_nxt  = nd_r + idx_t'(1);
        if (quot_step == '0) begin
          idx_nxt       = nd_r + idx_t'(1);
          sign_pend_nxt = neg_r;
          total_nxt     = len_t'(nd_r) + len_t'(1) + len_t'(neg_r);
          state_nxt     = ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = total_r;
          if (sign_pend_r) begin
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = digit_char(dig_r[idx_r - idx_t'(1)], mode_r == MODE_HEXU);
            out_last_nxt = (idx_r == idx_t'(1));
            idx_nxt      = idx_r - idx_t'(1);
            if (idx_r == idx_t'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r       <= mag_nxt;
    quot_r      <= quot_nxt;
    mode_r      <= mode_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    nd_r        <= nd_nxt;
    idx_r       <= idx_nxt;
    total_r     <= total_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_len_r   <= out_len_nxt;
    if (dig_we) begin
      dig_r[nd_r] <= digit;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.char_code    = out_char_r;
  assign out_bus.last         = out_last_r;
  assign out_bus.total_length = out_len_r;

  // The digit count never runs past the digit buffer.
  a_nd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (nd_r <= idx_t'(DIG_DEPTH)))
    else $error("digit count exceeds buffer depth");

  // While emitting there is always a character left to send.
  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r != '0 || sign_pend_r))
    else $error("emit state with nothing left to send");

  // A taken beat that is not the last is followed at once by the next character.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bus.ready && !out_last_r) |=> out_valid_r)
    else $error("gap inside a number");

  // The input is only taken when no digits are being worked on.
  a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL && nd_r == '0))
    else $error("accepted number did not start extraction");

endmodule

### verif/integer_to_ascii_formatter_tb.sv
module integer_to_ascii_formatter_tb;
  import itoa_pkg::*;

  typedef struct packed {
    char_t code;
    logic  last;
    len_t  length;
  } text_beat_t;

  class text_scoreboard;
    text_beat_t pending_text[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_number(value_t value, mode_t mode);
      value_t      magnitude;
      int unsigned radix;
      int unsigned digit;
      logic        negative;
      char_t       text[$];
      char_t       ch;
      text_beat_t  beat;
      negative  = (mode == MODE_SDEC) && value[VALUE_WIDTH-1];
      magnitude = negative ? -value : value;
      radix     = (mode == MODE_HEXL || mode == MODE_HEXU) ? 16 : 10;
      do begin
        digit = magnitude % radix;
        if (digit < 10) begin
          ch = CHAR_ZERO + char_t'(digit);
        end else if (mode == MODE_HEXU) begin
          ch = CHAR_UP_A + char_t'(digit - 10);
        end else begin
          ch = CHAR_LOW_A + char_t'(digit - 10);
        end
        text.push_front(ch);
        magnitude = magnitude / radix;
      end while (magnitude != 0);
      if (negative) begin
        text.push_front(CHAR_MINUS);
      end
      foreach (text[i]) begin
        beat.code   = text[i];
        beat.last   = (i == text.size() - 1);
        beat.length = len_t'(text.size());
        pending_text.push_back(beat);
      end
    endfunction

    function void check_char(char_t code, logic last, len_t length);
      text_beat_t want;
      if (pending_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected character beat: code %h last %b length %0d",
                   code, last, length);
        end
        return;
      end
      want = pending_text.pop_front();
      if (code !== want.code || last !== want.last || length !== want.length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Character mismatch: expected code %h last %b length %0d, got %h %b %0d",
                   want.code, want.last, want.length, code, last, length);
        end
      end
    endfunction

    function int outstanding();
      return pending_text.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   recv_hold;
  int   cycle_count;
  mode_t all_modes [4];

  text_scoreboard text_sb;

  itoa_in_if  in_bus ();
  itoa_out_if out_bus ();

  integer_to_ascii_formatter u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        text_sb.check_char(out_bus.char_code, out_bus.last, out_bus.total_length);
      end
      if (in_bus.valid && in_bus.ready) begin
        text_sb.note_number(value_t'(in_bus.value), in_bus.mode);
      end
    end
  end

  // The receiver may be held off for a long stretch to back the block up.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_number(input value_t value, input mode_t mode);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= value;
    in_bus.mode  <= mode;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (text_sb.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic value_t random_value();
    value_t      power;
    int unsigned exponent;
    power = 1;
    case ($urandom_range(0, 5))
      0: return value_t'($urandom_range(0, 99));
      1: begin
        exponent = $urandom_range(0, 9);
        repeat (exponent) power = power * 10;
        return power - value_t'($urandom_range(0, 1));
      end
      2: return -value_t'($urandom_range(1, 1000));
      3: return (value_t'(1) << $urandom_range(0, 31)) - value_t'($urandom_range(0, 1));
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_number(random_value(), mode_t'($urandom_range(0, 3)));
  endtask

  initial begin
    text_sb       = new();
    all_modes     = '{MODE_SDEC, MODE_UDEC, MODE_HEXL, MODE_HEXU};
    cycle_count   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 48;
    recv_hold     = 0;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    in_bus.mode   = MODE_SDEC;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (all_modes[i]) begin
      send_number(32'h0000_0000, all_modes[i]);
      send_number(32'h8000_0000, all_modes[i]);
      send_number(32'h7FFF_FFFF, all_modes[i]);
      send_number(32'hFFFF_FFFF, all_modes[i]);
    end
    send_number(32'd9, MODE_SDEC);
    send_number(32'd10, MODE_UDEC);
    send_number(32'd15, MODE_HEXL);
    send_number(32'd16, MODE_HEXU);
    send_number(32'd255, MODE_HEXL);
    send_number(32'hDEAD_BEEF, MODE_HEXU);
    send_number(-32'sd10, MODE_SDEC);
    send_number(32'd1_000_000_000, MODE_SDEC);
    send_number(32'hFEDC_BA98, MODE_HEXL);

    send_random(50);
    recv_hold = 300;
    send_random(50);
    wait_drained();

    send_idle_pct = 48;
    recv_idle_pct = 38;
    send_random(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 400;
    send_random(100);

    wait_drained();
    repeat (40) @(posedge clk);
    if (text_sb.mismatches == 0 && text_sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
src/itoa_pkg.sv
src/itoa_if.sv
src/integer_to_ascii_formatter.sv
verif/integer_to_ascii_formatter_tb.sv
